@@ design/msp_pkg.sv @@
// Shared types and constants for the MSP v1 response parser.
package msp_pkg;

  localparam logic [7:0] MARK0 = 8'h24;
  localparam logic [7:0] MARK1 = 8'h4D;
  localparam logic [7:0] MARK2 = 8'h3E;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_SUM = 2'd1;
  localparam logic [1:0] ST_BAD_HDR = 2'd2;
  localparam logic [1:0] ST_BAD_CMD = 2'd3;

  localparam logic [1:0] CFG_EXP_CMD = 2'd0;
  localparam logic [1:0] CFG_MATCH   = 2'd1;
  localparam logic [1:0] CFG_MAX_PAY = 2'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
    logic [1:0] status;
    logic       last;
  } msp_res_t;

  typedef struct packed {
    logic [7:0] expected_command;
    logic       match_enable;
    logic [7:0] max_payload;
  } msp_cfg_t;

endpackage

@@ design/msp_front.sv @@
// Front end: byte acceptance, frame parsing and result word generation.
module msp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  msp_pkg::msp_cfg_t cfg,
  input  logic              q_full,
  output logic              push,
  output msp_pkg::msp_res_t push_word
);
  import msp_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CHECK   = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [2:0] hdr_cnt_r, hdr_cnt_nxt;
  logic       hdr_good_r, hdr_good_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] pay_cnt_r, pay_cnt_nxt;
  logic [7:0] pay_cnt_inc;
  logic       acc;
  logic [7:0] b;

  assign in_stall    = q_full;
  assign acc         = in_valid & ~q_full;
  assign b           = in_rx_byte;
  assign pay_cnt_inc = pay_cnt_r + 8'd1;

  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    hdr_good_nxt = hdr_good_r;
    len_nxt      = len_r;
    cmd_nxt      = cmd_r;
    sum_nxt      = sum_r;
    pay_cnt_nxt  = pay_cnt_r;
    push         = 1'b0;
    push_word    = '0;
    if (acc) begin
      unique case (phase_r)
        PH_PAYLOAD: begin
          sum_nxt     = sum_r ^ b;
          pay_cnt_nxt = pay_cnt_inc;
          if (pay_cnt_r < cfg.max_payload) begin
            push                    = 1'b1;
            push_word.payload_byte  = b;
            push_word.byte_index    = pay_cnt_r;
            push_word.frame_command = cmd_r;
            push_word.frame_length  = len_r;
          end
          if (pay_cnt_inc == len_r) phase_nxt = PH_CHECK;
        end
        PH_CHECK: begin
          push                    = 1'b1;
          push_word.kind          = 1'b1;
          push_word.last          = 1'b1;
          push_word.frame_command = cmd_r;
          push_word.frame_length  = len_r;
          if (b != sum_r) begin
            push_word.status = ST_BAD_SUM;
          end else if (cfg.match_enable && cmd_r != cfg.expected_command) begin
            push_word.status = ST_BAD_CMD;
          end else begin
            push_word.status = ST_OK;
          end
          phase_nxt    = PH_HEADER;
          hdr_cnt_nxt  = 3'd0;
          hdr_good_nxt = 1'b1;
        end
        default: begin
          phase_nxt = PH_HEADER;
          case (hdr_cnt_r)
            3'd0: if (b != MARK0) hdr_good_nxt = 1'b0;
            3'd1: if (b != MARK1) hdr_good_nxt = 1'b0;
            3'd2: if (b != MARK2) hdr_good_nxt = 1'b0;
            3'd3: len_nxt = b;
            default: cmd_nxt = b;
          endcase
          if (hdr_cnt_r < 3'd4) begin
            hdr_cnt_nxt = hdr_cnt_r + 3'd1;
          end else if (!hdr_good_r) begin
            push                    = 1'b1;
            push_word.kind          = 1'b1;
            push_word.last          = 1'b1;
            push_word.frame_command = b;
            push_word.status        = ST_BAD_HDR;
            hdr_cnt_nxt             = 3'd0;
            hdr_good_nxt            = 1'b1;
          end else begin
            hdr_cnt_nxt  = 3'd0;
            hdr_good_nxt = 1'b1;
            sum_nxt      = len_r ^ b;
            pay_cnt_nxt  = 8'd0;
            phase_nxt    = (len_r == 8'd0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hdr_cnt_r  <= 3'd0;
      hdr_good_r <= 1'b1;
      len_r      <= 8'd0;
      cmd_r      <= 8'd0;
      sum_r      <= 8'd0;
      pay_cnt_r  <= 8'd0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      hdr_good_r <= hdr_good_nxt;
      len_r      <= len_nxt;
      cmd_r      <= cmd_nxt;
      sum_r      <= sum_nxt;
      pay_cnt_r  <= pay_cnt_nxt;
    end
  end

endmodule

@@ design/msp_fifo.sv @@
// Short result word queue between the parser and the output stage.
module msp_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  msp_pkg::msp_res_t push_word,
  input  logic              pop,
  output msp_pkg::msp_res_t pop_word,
  output logic              empty,
  output logic              full
);
  import msp_pkg::*;

  msp_res_t                 mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]       cnt_r, cnt_nxt;
  logic                     do_push;
  logic                     do_pop;

  assign empty    = (cnt_r == FIFO_CW'(0));
  assign full     = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_word = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? FIFO_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? FIFO_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + FIFO_CW'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - FIFO_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ design/msp_back.sv @@
// Back end: output register stage that drives the result channel.
module msp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  msp_pkg::msp_res_t q_word,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output msp_pkg::msp_res_t out_word
);
  import msp_pkg::*;

  logic     out_valid_r, out_valid_nxt;
  msp_res_t word_r;

  assign pop           = ~q_empty & (~out_valid_r | ~out_stall);
  assign out_valid_nxt = pop | (out_valid_r & out_stall);
  assign out_valid     = out_valid_r;
  assign out_word      = word_r;

  always_ff @(posedge clk) begin
    if (pop) word_r <= q_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ design/msp_v1_response_parser.sv @@
// Top level of the MSP v1 response parser: config registers, parser, queue, output stage.
// Throughput: one received byte per cycle while the result queue has room.
// A result word is written into the queue, then loaded into the output register that drives out_*.
// The four-word queue and output register absorb output stalls; in_stall rises when it fills.
// Reset (synchronous, rst_n low) returns the parser to header search and empties the queue.
// Config resets to expected_command 0, match_enable 0, max_payload 255.
module msp_v1_response_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_byte_index,
  output logic [7:0] out_frame_command,
  output logic [7:0] out_frame_length,
  output logic [1:0] out_status,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import msp_pkg::*;

  msp_cfg_t cfg_r;
  msp_res_t push_word;
  msp_res_t q_word;
  msp_res_t out_word;
  logic     push;
  logic     pop;
  logic     q_empty;
  logic     q_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_command <= 8'd0;
      cfg_r.match_enable     <= 1'b0;
      cfg_r.max_payload      <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EXP_CMD: cfg_r.expected_command <= cfg_data;
        CFG_MATCH:   cfg_r.match_enable     <= cfg_data[0];
        CFG_MAX_PAY: cfg_r.max_payload      <= cfg_data;
        default: ;
      endcase
    end
  end

  msp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .cfg        (cfg_r),
    .q_full     (q_full),
    .push       (push),
    .push_word  (push_word)
  );

  msp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (q_word),
    .empty     (q_empty),
    .full      (q_full)
  );

  msp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_word    (q_word),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign out_kind          = out_word.kind;
  assign out_payload_byte  = out_word.payload_byte;
  assign out_byte_index    = out_word.byte_index;
  assign out_frame_command = out_word.frame_command;
  assign out_frame_length  = out_word.frame_length;
  assign out_status        = out_word.status;
  assign out_last          = out_word.last;

endmodule

@@ test/tb_msp_v1_response_parser.sv @@
// Self-checking testbench for msp_v1_response_parser: random frames, stalls and config phases.
`timescale 1ns / 100ps

module tb_msp_v1_response_parser;
  import msp_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_BYTES  = 230;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE_TICKS = 4;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2
  } parse_phase_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_kind;
  logic [7:0] out_payload_byte;
  logic [7:0] out_byte_index;
  logic [7:0] out_frame_command;
  logic [7:0] out_frame_length;
  logic [1:0] out_status;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_EXP_CMD;
  logic [7:0] cfg_data = 8'h00;

  msp_v1_response_parser u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_payload_byte  (out_payload_byte),
    .out_byte_index    (out_byte_index),
    .out_frame_command (out_frame_command),
    .out_frame_length  (out_frame_length),
    .out_status        (out_status),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parser mirror
  logic [7:0]   want_cmd = 8'h00;
  logic         want_match = 1'b0;
  logic [7:0]   want_max_pay = 8'hFF;
  parse_phase_e ph = PH_HEADER;
  logic [2:0]   hdr_cnt = 3'd0;
  logic         hdr_ok = 1'b1;
  logic [7:0]   len_r = 8'h00;
  logic [7:0]   cmd_r = 8'h00;
  logic [7:0]   sum_acc = 8'h00;
  logic [7:0]   pay_cnt = 8'h00;

  msp_res_t   parsed_words[$];
  logic [7:0] link_bytes[$];
  int         bytes_queued = 0;
  int         mismatch_count = 0;
  int         cycles = 0;
  bit         in_took = 1'b0;
  int         tx_wait = 0;
  int         rx_wait = 0;
  int         tx_gap_max = 10;
  int         rx_gap_max = 10;
  int         rx_hold_left = 0;

  function automatic void parse_byte(input logic [7:0] b);
    msp_res_t r;
    r = '0;
    case (ph)
      PH_PAYLOAD: begin
        sum_acc = sum_acc ^ b;
        if (pay_cnt < want_max_pay) begin
          r.payload_byte  = b;
          r.byte_index    = pay_cnt;
          r.frame_command = cmd_r;
          r.frame_length  = len_r;
          parsed_words.push_back(r);
        end
        pay_cnt = pay_cnt + 8'd1;
        if (pay_cnt == len_r) ph = PH_CHECK;
      end
      PH_CHECK: begin
        r.kind          = 1'b1;
        r.last          = 1'b1;
        r.frame_command = cmd_r;
        r.frame_length  = len_r;
        if (b != sum_acc) r.status = ST_BAD_SUM;
        else if (want_match && cmd_r != want_cmd) r.status = ST_BAD_CMD;
        else r.status = ST_OK;
        parsed_words.push_back(r);
        ph      = PH_HEADER;
        hdr_cnt = 3'd0;
        hdr_ok  = 1'b1;
      end
      default: begin
        ph = PH_HEADER;
        case (hdr_cnt)
          3'd0: if (b != MARK0) hdr_ok = 1'b0;
          3'd1: if (b != MARK1) hdr_ok = 1'b0;
          3'd2: if (b != MARK2) hdr_ok = 1'b0;
          3'd3: len_r = b;
          default: cmd_r = b;
        endcase
        if (hdr_cnt < 3'd4) begin
          hdr_cnt = hdr_cnt + 3'd1;
        end else if (!hdr_ok) begin
          r.kind          = 1'b1;
          r.last          = 1'b1;
          r.frame_command = b;
          r.status        = ST_BAD_HDR;
          parsed_words.push_back(r);
          hdr_cnt = 3'd0;
          hdr_ok  = 1'b1;
        end else begin
          hdr_cnt = 3'd0;
          sum_acc = len_r ^ cmd_r;
          pay_cnt = 8'h00;
          ph      = (len_r == 8'h00) ? PH_CHECK : PH_PAYLOAD;
        end
      end
    endcase
  endfunction

  function automatic void flag_word(input msp_res_t want, input msp_res_t got, input bit orphan);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (orphan)
        $display("unexpected word (kind/byte/idx/cmd/len/st/last): %0d/%02h/%0d/%02h/%0d/%0d/%0d",
                 got.kind, got.payload_byte, got.byte_index, got.frame_command,
                 got.frame_length, got.status, got.last);
      else
        $display("word mismatch (kind/byte/idx/cmd/len/st/last): exp %0d/%02h/%0d/%02h/%0d/%0d/%0d",
                 want.kind, want.payload_byte, want.byte_index, want.frame_command,
                 want.frame_length, want.status, want.last,
                 "  got %0d/%02h/%0d/%02h/%0d/%0d/%0d",
                 got.kind, got.payload_byte, got.byte_index, got.frame_command,
                 got.frame_length, got.status, got.last);
    end
  endfunction

  // accept, predict and check on the rising edge
  always @(posedge clk) begin
    msp_res_t got;
    msp_res_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_msp_v1_response_parser failed");
      $finish;
    end else if (rst_n) begin
      in_took = in_valid && !in_stall;
      if (in_took) parse_byte(in_rx_byte);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_EXP_CMD: want_cmd = cfg_data;
          CFG_MATCH:   want_match = cfg_data[0];
          CFG_MAX_PAY: want_max_pay = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {out_kind, out_payload_byte, out_byte_index, out_frame_command,
               out_frame_length, out_status, out_last};
        rx_wait = $urandom_range(0, rx_gap_max);
        if (parsed_words.size() == 0) begin
          flag_word(got, got, 1'b1);
        end else begin
          want = parsed_words.pop_front();
          if (got !== want) flag_word(want, got, 1'b0);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rx_hold_left > 0) rx_hold_left--;
  end

  // byte driver
  always @(negedge clk) begin
    logic offer;
    offer = in_valid;
    if (rst_n && (!in_valid || in_took)) begin
      offer = 1'b0;
      if (tx_wait > 0) begin
        tx_wait--;
      end else if (link_bytes.size() > 0) begin
        in_rx_byte <= link_bytes.pop_front();
        tx_wait = $urandom_range(0, tx_gap_max);
        offer = 1'b1;
      end
    end
    in_valid <= offer;
  end

  // result back-pressure
  always @(negedge clk) begin
    out_stall <= rst_n && (rx_hold_left > 0 || rx_wait > 0);
    if (rx_wait > 0) rx_wait--;
  end

  function automatic void put(input logic [7:0] b);
    link_bytes.push_back(b);
    bytes_queued++;
  endfunction

  // bad_mark 0..2 corrupts that marker and ends after the header
  task automatic queue_frame(input logic [7:0] cmd, input logic [7:0] len, input bit sum_ok,
                             input int bad_mark);
    logic [7:0] acc;
    logic [7:0] b;
    acc = len ^ cmd;
    for (int i = 0; i < 3; i++) begin
      b = (i == 0) ? MARK0 : (i == 1) ? MARK1 : MARK2;
      if (i == bad_mark) b = b ^ 8'($urandom_range(1, 255));
      put(b);
    end
    put(len);
    put(cmd);
    if (bad_mark < 0) begin
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom_range(0, 255));
        acc = acc ^ b;
        put(b);
      end
      put(sum_ok ? acc : acc ^ 8'($urandom_range(1, 255)));
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (link_bytes.size() != 0 || in_valid || parsed_words.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  initial begin
    logic [7:0] exp_cmd;
    logic       match;
    logic [7:0] max_pay;
    logic [7:0] len;
    int         r;
    int         target;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset config
    queue_frame(8'hFF, 8'h00, 1'b1, -1);
    queue_frame(8'h00, 8'h00, 1'b1, 0);
    queue_frame(8'h00, 8'h01, 1'b0, -1);
    settle();

    // directed: truncation and wrong command
    cfg_write(CFG_EXP_CMD, 8'h10);
    cfg_write(CFG_MATCH, 8'h01);
    cfg_write(CFG_MAX_PAY, 8'h01);
    queue_frame(8'h11, 8'h02, 1'b1, -1);
    settle();

    target = bytes_queued;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin exp_cmd = 8'h00; match = 1'b0; max_pay = 8'hFF; end
        1: begin exp_cmd = 8'hFF; match = 1'b1; max_pay = 8'h00; end
        2: begin exp_cmd = 8'($urandom_range(0, 255)); match = 1'b1; max_pay = 8'hFF; end
        3: begin exp_cmd = 8'h00; match = 1'b1; max_pay = 8'h01; end
        default: begin
          exp_cmd = 8'($urandom_range(0, 255));
          match   = 1'($urandom_range(0, 1));
          max_pay = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 12));
        end
      endcase
      cfg_write(CFG_EXP_CMD, exp_cmd);
      cfg_write(CFG_MATCH, {7'd0, match});
      cfg_write(CFG_MAX_PAY, max_pay);
      tx_gap_max = (p % 3 == 0) ? 0 : 10;
      rx_gap_max = (p % 4 == 1) ? 0 : 10;
      if (p == 2) rx_hold_left = LONG_HOLD;

      target += PHASE_BYTES;
      while (bytes_queued < target) begin
        r = $urandom_range(0, 99);
        if (r < 70) len = 8'($urandom_range(0, 6));
        else if (r < 97) len = 8'($urandom_range(7, 24));
        else len = 8'($urandom_range(25, 255));
        r = $urandom_range(0, 99);
        if (r < 8) begin
          // whole header-sized chunks of noise keep the frame boundaries aligned
          repeat (5 * $urandom_range(1, 2)) put(8'($urandom_range(0, 255)));
        end else if (r < 16) begin
          queue_frame(8'($urandom_range(0, 255)), len, 1'b1, $urandom_range(0, 2));
        end else begin
          queue_frame($urandom_range(0, 1) ? exp_cmd : 8'($urandom_range(0, 255)), len,
                      $urandom_range(0, 99) < 85, -1);
        end
      end
      settle();
    end

    if (mismatch_count == 0 && parsed_words.size() == 0)
      $display("tb_msp_v1_response_parser passed");
    else
      $display("tb_msp_v1_response_parser failed");
    $finish;
  end

endmodule
